[sv/weighted_tcp_window_update_assert.svh]
// Assertion macros used by the weighted TCP window update queue.
// Expects clk and rst_n in scope where used.
`ifndef WEIGHTED_TCP_WINDOW_UPDATE_ASSERT_SVH
`define WEIGHTED_TCP_WINDOW_UPDATE_ASSERT_SVH

// cond must never hold
`define WTCPWU_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("wtcpwu: assertion failed");

// ante implies cons in the next cycle
`define WTCPWU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wtcpwu: assertion failed");

`endif

[sv/wtcpwu_pkg.sv]
// Types and constants for the weighted TCP window update block.
// No dependencies.
`default_nettype none
package wtcpwu_pkg;

  localparam int DVD_W    = 41;  // dividend width: w*seg*seg or bif*(2w-1)
  localparam int DIV_STEPS = DVD_W;

  localparam logic [1:0] REG_SEGMENT_SIZE = 2'd0;
  localparam logic [1:0] REG_FLOW_WEIGHT  = 2'd1;
  localparam logic [1:0] REG_DOUBLE_LIMIT = 2'd2;

  localparam logic FUNC_ACK  = 1'b0;
  localparam logic FUNC_LOSS = 1'b1;

  // classified item handed from front to back
  typedef struct packed {
    logic             func;
    logic [31:0]      win;       // window after slow start (ack) or original (loss)
    logic [31:0]      thr;
    logic             ca;        // congestion avoidance increment applies
    logic             lt;        // window was below threshold
    logic [31:0]      bif;
    logic [DVD_W-1:0] dividend;
    logic [31:0]      divisor;
  } item_t;

  typedef struct packed {
    item_t            it;
    logic [31:0]      rem;
    logic [DVD_W-1:0] dq;        // dividend bits shifting out, quotient in
  } bstage_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

[sv/wtcpwu_front.sv]
// Front end: accepts items, applies slow start and forms divider operands.
// Depends on wtcpwu_pkg.
`default_nettype none
module wtcpwu_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_func,
  input  wire logic [31:0]          in_window_now,
  input  wire logic [31:0]          in_threshold_now,
  input  wire logic [15:0]          in_segments_acked,
  input  wire logic [31:0]          in_bytes_in_flight,
  input  wire logic [15:0]          seg_size,
  input  wire logic [7:0]           flow_weight,
  input  wire logic [31:0]          dbl_limit,
  input  wire wtcpwu_pkg::q_stat_t  q_stat,
  output logic                      q_push,
  output wtcpwu_pkg::item_t         q_data
);

  logic        en_f;
  logic        a_v_r;
  logic        a_func_r, a_lt_r, a_le_r, a_nz_r, a_gt1_r;
  logic [31:0] a_win_r, a_thr_r, a_bif_r;
  logic [31:0] seg_sq_r;
  logic        b_v_r;
  wtcpwu_pkg::item_t b_item_r, b_item_nxt;

  logic        ss;
  logic [16:0] inc;
  logic [32:0] ss_sum;
  logic [31:0] win1;
  logic        more;
  logic [7:0]  w1;
  logic [8:0]  mul_b;
  logic [31:0] mul_a;
  logic [40:0] prod;

  assign en_f     = !(b_v_r && q_stat.full);
  assign in_stall = !en_f;
  assign q_push   = b_v_r && en_f;
  assign q_data   = b_item_r;

  always_ff @(posedge clk) begin
    seg_sq_r <= {16'd0, seg_size} * {16'd0, seg_size};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (en_f) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      a_func_r <= in_func;
      a_win_r  <= in_window_now;
      a_thr_r  <= in_threshold_now;
      a_bif_r  <= in_bytes_in_flight;
      a_lt_r   <= in_window_now < in_threshold_now;
      a_le_r   <= in_window_now <= dbl_limit;
      a_nz_r   <= in_segments_acked != 16'd0;
      a_gt1_r  <= in_segments_acked > 16'd1;
      b_item_r <= b_item_nxt;
    end
  end

  always_comb begin
    ss     = a_lt_r && a_nz_r;
    inc    = a_le_r ? {seg_size, 1'b0} : {1'b0, seg_size};
    ss_sum = {1'b0, a_win_r} + {16'd0, inc};
    win1   = !ss ? a_win_r : (ss_sum[32] ? 32'hFFFF_FFFF : ss_sum[31:0]);
    more   = ss ? a_gt1_r : a_nz_r;
    w1     = (flow_weight == 8'd0) ? 8'd1 : flow_weight;
    // one multiplier: bif*(2w-1) on loss, w*seg^2 on ack
    mul_a  = (a_func_r == wtcpwu_pkg::FUNC_LOSS) ? a_bif_r : seg_sq_r;
    mul_b  = (a_func_r == wtcpwu_pkg::FUNC_LOSS) ? ({w1, 1'b0} - 9'd1) : {1'b0, flow_weight};
    prod   = {9'd0, mul_a} * {32'd0, mul_b};

    b_item_nxt.func     = a_func_r;
    b_item_nxt.thr      = a_thr_r;
    b_item_nxt.lt       = a_lt_r;
    b_item_nxt.bif      = a_bif_r;
    b_item_nxt.dividend = prod;
    if (a_func_r == wtcpwu_pkg::FUNC_LOSS) begin
      b_item_nxt.win     = a_win_r;
      b_item_nxt.ca      = 1'b0;
      b_item_nxt.divisor = {23'd0, w1, 1'b0};
    end else begin
      b_item_nxt.win     = win1;
      b_item_nxt.ca      = (win1 >= a_thr_r) && more;
      b_item_nxt.divisor = win1;
    end
  end

endmodule
`default_nettype wire

[sv/wtcpwu_queue.sv]
// Short queue between front and back ends.
// Depends on wtcpwu_pkg and weighted_tcp_window_update_assert.svh.
`default_nettype none
`include "weighted_tcp_window_update_assert.svh"
module wtcpwu_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire wtcpwu_pkg::item_t   push_data,
  input  wire logic                pop,
  output wtcpwu_pkg::item_t        pop_data,
  output wtcpwu_pkg::q_stat_t      stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wtcpwu_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign stat.full  = cnt_r == CW'(DEPTH);
  assign stat.empty = cnt_r == '0;
  assign pop_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `WTCPWU_ASSERT_NEVER(a_no_overflow, push && stat.full)
  `WTCPWU_ASSERT_NEVER(a_no_underflow, pop && stat.empty)
  `WTCPWU_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule
`default_nettype wire

[sv/wtcpwu_back.sv]
// Back end: pipelined restoring divider, final add/saturate, output register.
// Depends on wtcpwu_pkg.
`default_nettype none
module wtcpwu_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire wtcpwu_pkg::q_stat_t  q_stat,
  input  wire wtcpwu_pkg::item_t    q_data,
  output logic                      q_pop,
  input  wire logic [15:0]          seg_size,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [31:0]               out_window_next,
  output logic [31:0]               out_threshold_next
);

  localparam int N = wtcpwu_pkg::DIV_STEPS;

  logic en_b;
  logic                v_r [N+1];
  wtcpwu_pkg::bstage_t s_r [N+1];
  wtcpwu_pkg::bstage_t s_nxt [N+1];
  logic        ov_r;
  logic [31:0] owin_r, othr_r;

  wtcpwu_pkg::item_t fit;
  logic [N-1:0] q;
  logic [N-1:0] add;
  logic [N:0]   sum;
  logic [31:0]  t_loss, floor_v;
  logic [31:0]  win_fin, thr_fin;

  assign en_b  = !ov_r || !out_stall;
  assign q_pop = en_b && !q_stat.empty;

  always_comb begin
    s_nxt[0].it  = q_data;
    s_nxt[0].rem = '0;
    s_nxt[0].dq  = q_data.dividend;
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= N; k++) begin : g_div
    logic [32:0] t;
    logic        qb;
    always_comb begin
      t  = {s_r[k-1].rem, s_r[k-1].dq[N-1]};
      qb = t >= {1'b0, s_r[k-1].it.divisor};
      if (qb) begin
        t = t - {1'b0, s_r[k-1].it.divisor};
      end
      s_nxt[k].it  = s_r[k-1].it;
      s_nxt[k].rem = t[31:0];
      s_nxt[k].dq  = {s_r[k-1].dq[N-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) begin
        v_r[k] <= 1'b0;
      end
      ov_r <= 1'b0;
    end else if (en_b) begin
      v_r[0] <= !q_stat.empty;
      for (int k = 1; k <= N; k++) begin
        v_r[k] <= v_r[k-1];
      end
      ov_r <= v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      for (int k = 0; k <= N; k++) begin
        s_r[k] <= s_nxt[k];
      end
      owin_r <= win_fin;
      othr_r <= thr_fin;
    end
  end

  always_comb begin
    fit     = s_r[N].it;
    q       = s_r[N].dq;
    add     = (fit.win == 32'd0 || q == '0) ? N'(1) : q;
    sum     = {{(N-31){1'b0}}, fit.win} + {1'b0, add};
    floor_v = {15'd0, seg_size, 1'b0};
    t_loss  = fit.lt ? {1'b0, fit.bif[31:1]} : q[31:0];
    if (fit.func == wtcpwu_pkg::FUNC_LOSS) begin
      win_fin = fit.win;
      thr_fin = (t_loss < floor_v) ? floor_v : t_loss;
    end else begin
      thr_fin = fit.thr;
      if (!fit.ca) begin
        win_fin = fit.win;
      end else if (sum[N:32] != '0) begin
        win_fin = 32'hFFFF_FFFF;
      end else begin
        win_fin = sum[31:0];
      end
    end
  end

  assign out_valid          = ov_r;
  assign out_window_next    = owin_r;
  assign out_threshold_next = othr_r;

endmodule
`default_nettype wire

[sv/weighted_tcp_window_update.sv]
// Weighted TCP congestion window update for one flow.
// Input channel: in_valid/in_stall; an item transfers when valid and not stalled.
// Each item is an ack (func 0) or loss (func 1) event and yields one result
// on out_valid/out_stall: the new window and slow start threshold.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index 0 segment
// size, 1 flow weight, 2 double growth limit. Write only while idle.
// Throughput: one item per cycle sustained while out_stall is low. From input
// transfer to out_valid an item passes two front stages, the queue, the
// 41-stage pipelined divider (one quotient bit per stage) and the output
// register.
// When out_stall is high while out_valid is set, the back end freezes; the front
// keeps accepting until the queue fills, then raises in_stall.
// Reset (rst_n low, synchronous) clears all valids and the queue and loads
// segment size 536, weight 1, double growth limit 1.
// Depends on wtcpwu_pkg, wtcpwu_front, wtcpwu_queue, wtcpwu_back.
`default_nettype none
module weighted_tcp_window_update #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [31:0] in_window_now,
  input  wire logic [31:0] in_threshold_now,
  input  wire logic [15:0] in_segments_acked,
  input  wire logic [31:0] in_bytes_in_flight,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_window_next,
  output logic [31:0]      out_threshold_next,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [15:0] seg_r;
  logic [7:0]  wt_r;
  logic [31:0] lim_r;

  wtcpwu_pkg::q_stat_t q_stat;
  wtcpwu_pkg::item_t   push_data, pop_data;
  logic                push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= 16'd536;
      wt_r  <= 8'd1;
      lim_r <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wtcpwu_pkg::REG_SEGMENT_SIZE: seg_r <= cfg_data[15:0];
        wtcpwu_pkg::REG_FLOW_WEIGHT:  wt_r  <= cfg_data[7:0];
        wtcpwu_pkg::REG_DOUBLE_LIMIT: lim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  wtcpwu_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_window_now      (in_window_now),
    .in_threshold_now   (in_threshold_now),
    .in_segments_acked  (in_segments_acked),
    .in_bytes_in_flight (in_bytes_in_flight),
    .seg_size           (seg_r),
    .flow_weight        (wt_r),
    .dbl_limit          (lim_r),
    .q_stat             (q_stat),
    .q_push             (push),
    .q_data             (push_data)
  );

  wtcpwu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  wtcpwu_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_stat             (q_stat),
    .q_data             (pop_data),
    .q_pop              (pop),
    .seg_size           (seg_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_window_next    (out_window_next),
    .out_threshold_next (out_threshold_next)
  );

endmodule
`default_nettype wire
